/* hdl/wba_pkg.sv */
// shared constants, types and codes for the windowed bitrate adapter
// used by every module of the block; depends on nothing

package wba_pkg;

  localparam int WINDOW       = 30;
  localparam int DECIDE_EVERY = 10;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int DEC_W  = $clog2(DECIDE_EVERY + 1);
  localparam int SUM_W  = 32 + $clog2(WINDOW);

  localparam int RATE_W = 32;
  localparam int KBPS_W = 31;
  localparam int SPAN_W = 64;
  localparam int MS_W   = 51;
  localparam int NUM_W  = 35;
  localparam int PROD_W = 38;
  localparam int DVD_W  = 64;
  localparam int CNT_W  = 6;

  localparam int TICKS_PER_MS = 10000;
  localparam int BYTE_SCALE   = 125;
  localparam int BYTE_SHIFT   = 4;

  localparam int RX_UP_WEIGHT   = 100;
  localparam int TX_UP_WEIGHT   = 98;
  localparam int RX_DOWN_WEIGHT = 10;
  localparam int TX_DOWN_WEIGHT = 9;
  localparam int UP_MUL         = 102;
  localparam int UP_DIV         = 100;
  localparam int DOWN_MUL       = 9;
  localparam int DOWN_DIV       = 10;

  localparam int MS_PAIRS  = 26;
  localparam int MS_PRE_W  = DVD_W - 2 * MS_PAIRS;
  localparam int RT_PAIRS  = (NUM_W + 1) / 2;
  localparam int RT_SHIFT  = DVD_W - 2 * RT_PAIRS;
  localparam int AVG_PAIRS = (SUM_W + 1) / 2;
  localparam int AVG_SHIFT = DVD_W - 2 * AVG_PAIRS;
  localparam int SUG_PAIRS = (PROD_W + 1) / 2;
  localparam int SUG_SHIFT = DVD_W - 2 * SUG_PAIRS;

  localparam int IN_W  = 224;
  localparam int OUT_W = 136;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_KBPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KBPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACHED = 2'd2;

  localparam logic [KBPS_W-1:0] MIN_KBPS_RST = 31'd200;
  localparam logic [KBPS_W-1:0] MAX_KBPS_RST = 31'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_RD,
    ST_PUSH,
    ST_CMP,
    ST_CLAMP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_MS_TX,
    OP_RT_TX,
    OP_MS_RX,
    OP_RT_RX,
    OP_AVG_TX,
    OP_AVG_RX,
    OP_SUG
  } op_e;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic             start;
    logic [MS_W-1:0]  rem_init;
    logic [DVD_W-1:0] dvd_init;
    logic [MS_W-1:0]  divisor;
    logic [CNT_W-1:0] pairs;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  typedef struct packed {
    logic rd;
    logic push;
  } hist_ctrl_t;

endpackage

/* hdl/wba_div.sv */
// shared restoring divider, two quotient bits per cycle
// depends on wba_pkg

module wba_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wba_pkg::div_req_t               req_i,
  output wba_pkg::div_rsp_t               rsp_o,
  output logic [wba_pkg::DVD_W-1:0]       quot_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [wba_pkg::CNT_W-1:0]     cnt_q;
  logic [wba_pkg::MS_W-1:0]      rem_q;
  logic [wba_pkg::MS_W-1:0]      den_q;
  logic [wba_pkg::DVD_W-1:0]     dvd_q;

  logic [wba_pkg::MS_W:0]        t1;
  logic [wba_pkg::MS_W:0]        t2;
  logic                          q1;
  logic                          q2;
  logic [wba_pkg::MS_W-1:0]      r1;
  logic [wba_pkg::MS_W-1:0]      r2;

  always_comb begin
    t1 = {rem_q, dvd_q[wba_pkg::DVD_W-1]};
    q1 = t1 >= {1'b0, den_q};
    r1 = q1 ? wba_pkg::MS_W'(t1 - {1'b0, den_q}) : t1[wba_pkg::MS_W-1:0];
    t2 = {r1, dvd_q[wba_pkg::DVD_W-2]};
    q2 = t2 >= {1'b0, den_q};
    r2 = q2 ? wba_pkg::MS_W'(t2 - {1'b0, den_q}) : t2[wba_pkg::MS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.pairs;
      end else if (busy_q) begin
        cnt_q <= cnt_q - wba_pkg::CNT_W'(1);
        if (cnt_q == wba_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      den_q <= req_i.divisor;
      dvd_q <= req_i.dvd_init;
    end else if (busy_q) begin
      rem_q <= r2;
      dvd_q <= {dvd_q[wba_pkg::DVD_W-3:0], q1, q2};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = dvd_q;

endmodule

/* hdl/wba_hist.sv */
// rate history: window memory of sent and received rates, running sums,
// fill count and decision counter; depends on wba_pkg

module wba_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wba_pkg::hist_ctrl_t           ctrl_i,
  input  logic [wba_pkg::RATE_W-1:0]    tx_i,
  input  logic [wba_pkg::RATE_W-1:0]    rx_i,
  output logic [wba_pkg::SUM_W-1:0]     tx_sum_o,
  output logic [wba_pkg::SUM_W-1:0]     rx_sum_o,
  output logic                          decide_o
);

  logic [2*wba_pkg::RATE_W-1:0] win_q [wba_pkg::WINDOW];
  logic [2*wba_pkg::RATE_W-1:0] rd_q;
  logic [wba_pkg::SLOT_W-1:0]   slot_q;
  logic [wba_pkg::FILL_W-1:0]   fill_q;
  logic [wba_pkg::DEC_W-1:0]    cnt_q;
  logic [wba_pkg::SUM_W-1:0]    tx_sum_q;
  logic [wba_pkg::SUM_W-1:0]    rx_sum_q;
  logic                         full;

  assign full     = fill_q == wba_pkg::FILL_W'(wba_pkg::WINDOW);
  assign decide_o = (fill_q >= wba_pkg::FILL_W'(wba_pkg::WINDOW - 1)) &&
                    (cnt_q >= wba_pkg::DEC_W'(wba_pkg::DECIDE_EVERY - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_q <= win_q[slot_q];
    end
    if (ctrl_i.push) begin
      win_q[slot_q] <= {rx_i, tx_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      tx_sum_q <= '0;
      rx_sum_q <= '0;
    end else if (ctrl_i.push) begin
      if (full) begin
        tx_sum_q <= tx_sum_q - wba_pkg::SUM_W'(rd_q[wba_pkg::RATE_W-1:0])
                    + wba_pkg::SUM_W'(tx_i);
        rx_sum_q <= rx_sum_q - wba_pkg::SUM_W'(rd_q[2*wba_pkg::RATE_W-1:wba_pkg::RATE_W])
                    + wba_pkg::SUM_W'(rx_i);
      end else begin
        fill_q   <= fill_q + wba_pkg::FILL_W'(1);
        tx_sum_q <= tx_sum_q + wba_pkg::SUM_W'(tx_i);
        rx_sum_q <= rx_sum_q + wba_pkg::SUM_W'(rx_i);
      end
      if (slot_q == wba_pkg::SLOT_W'(wba_pkg::WINDOW - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + wba_pkg::SLOT_W'(1);
      end
      if (decide_o) begin
        cnt_q <= '0;
      end else if (cnt_q < wba_pkg::DEC_W'(wba_pkg::DECIDE_EVERY)) begin
        cnt_q <= cnt_q + wba_pkg::DEC_W'(1);
      end
    end
  end

  assign tx_sum_o = tx_sum_q;
  assign rx_sum_o = rx_sum_q;

endmodule

/* hdl/windowed_bitrate_adapter.sv */
// channel  side    handshake             beat
// s_axis   in      tvalid/tready         one report, 224 bits
// m_axis   out     tvalid/tready         one decision, 136 bits
// cfg      in      cfg_we_i              one register write, no wait
//
// a report takes four divisions on the shared divider
// (span to ms and bytes to kbps, twice each), then a window read and write
// a decision adds two averages and a compare, then a suggestion division
// and a clamp unless it holds, and it may wait on the output
// a zero millisecond count skips its rate division
// reset clears control, sums and counters at once; window memory needs no clearing
// a finished decision waits in the output register while the next report is taken
//
// top level; depends on wba_pkg, wba_div and wba_hist

module windowed_bitrate_adapter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sent_bytes, received_bytes, local_span, remote_span, current_kbps, zero fill
  input  logic [wba_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // avg_sent_kbps, avg_received_kbps, prior_kbps, next_kbps, direction, apply_rate, zero fill
  output logic [wba_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [wba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wba_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int RW = wba_pkg::RATE_W;
  localparam int KW = wba_pkg::KBPS_W;

  wba_pkg::state_e state_q, state_d;
  wba_pkg::op_e    op_q, op_d;
  wba_pkg::dir_e   dir_q, dir_c;

  logic [KW-1:0]             min_q, max_q;
  logic                      attached_q;

  logic [RW-1:0]             sent_q, recv_q;
  logic [wba_pkg::SPAN_W-1:0] lspan_q, rspan_q;
  logic [KW-1:0]             cur_q;
  logic [wba_pkg::MS_W-1:0]  ms_q;
  logic [RW-1:0]             tx_q, rx_q;
  logic [RW-1:0]             avg_tx_q, avg_rx_q;
  logic [RW-1:0]             sug_q;
  logic [KW-1:0]             next_q;

  logic                      out_valid_q;
  logic [RW-1:0]             o_avg_tx_q, o_avg_rx_q;
  logic [KW-1:0]             o_prior_q, o_next_q;
  wba_pkg::dir_e             o_dir_q;
  logic                      o_apply_q;

  wba_pkg::div_req_t         div_req;
  wba_pkg::div_rsp_t         div_rsp;
  logic [wba_pkg::DVD_W-1:0] quot;
  wba_pkg::hist_ctrl_t       hist_ctrl;
  logic [wba_pkg::SUM_W-1:0] tx_sum, rx_sum;
  logic                      decide;

  logic                      s_accept;
  logic                      ignore;
  logic                      ms_zero;
  logic                      rt_op;
  logic                      out_load;
  logic [RW-1:0]             rate_sat;
  logic [RW-1:0]             bytes_sel;
  logic [wba_pkg::SPAN_W-1:0] span_sel;
  logic [RW+7-1:0]           bytes_prod;
  logic [wba_pkg::PROD_W-1:0] sug_prod;
  logic [RW+7-1:0]           rx_up, tx_up, rx_dn, tx_dn;
  logic [RW-1:0]             lo_clamp, hi_clamp;

  assign s_axis_tready = state_q == wba_pkg::ST_IDLE;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ignore        = (min_q >= max_q) || !attached_q;
  assign ms_zero       = ms_q == '0;
  assign rt_op         = (op_q == wba_pkg::OP_RT_TX) || (op_q == wba_pkg::OP_RT_RX);
  assign out_load      = (state_q == wba_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
  assign rate_sat      = (quot[wba_pkg::DVD_W-1:RW] != '0) ? '1 : quot[RW-1:0];

  wba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp),
    .quot_o (quot)
  );

  wba_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (hist_ctrl),
    .tx_i     (tx_q),
    .rx_i     (rx_q),
    .tx_sum_o (tx_sum),
    .rx_sum_o (rx_sum),
    .decide_o (decide)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= wba_pkg::MIN_KBPS_RST;
      max_q      <= wba_pkg::MAX_KBPS_RST;
      attached_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wba_pkg::REG_MIN_KBPS: min_q      <= cfg_data_i;
        wba_pkg::REG_MAX_KBPS: max_q      <= cfg_data_i;
        wba_pkg::REG_ATTACHED: attached_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // divider operand selection
  always_comb begin
    bytes_sel  = (op_q == wba_pkg::OP_RT_TX) ? sent_q : recv_q;
    span_sel   = (op_q == wba_pkg::OP_MS_TX) ? lspan_q : rspan_q;
    bytes_prod = (RW + 7)'(bytes_sel) * (RW + 7)'(wba_pkg::BYTE_SCALE);
    sug_prod   = (dir_q == wba_pkg::DIR_UP) ?
                 wba_pkg::PROD_W'(cur_q) * wba_pkg::PROD_W'(wba_pkg::UP_MUL) :
                 wba_pkg::PROD_W'(cur_q) * wba_pkg::PROD_W'(wba_pkg::DOWN_MUL);
    div_req          = '0;
    div_req.divisor  = wba_pkg::MS_W'(wba_pkg::TICKS_PER_MS);
    div_req.pairs    = wba_pkg::CNT_W'(wba_pkg::MS_PAIRS);
    case (op_q)
      wba_pkg::OP_MS_TX, wba_pkg::OP_MS_RX: begin
        div_req.rem_init = wba_pkg::MS_W'(span_sel[wba_pkg::SPAN_W-1:
                                                   wba_pkg::SPAN_W-wba_pkg::MS_PRE_W]);
        div_req.dvd_init = span_sel << wba_pkg::MS_PRE_W;
      end
      wba_pkg::OP_RT_TX, wba_pkg::OP_RT_RX: begin
        div_req.divisor  = ms_q;
        div_req.pairs    = wba_pkg::CNT_W'(wba_pkg::RT_PAIRS);
        div_req.dvd_init = wba_pkg::DVD_W'(bytes_prod[RW+7-1:wba_pkg::BYTE_SHIFT])
                           << wba_pkg::RT_SHIFT;
      end
      wba_pkg::OP_AVG_TX, wba_pkg::OP_AVG_RX: begin
        div_req.divisor  = wba_pkg::MS_W'(wba_pkg::WINDOW);
        div_req.pairs    = wba_pkg::CNT_W'(wba_pkg::AVG_PAIRS);
        div_req.dvd_init = wba_pkg::DVD_W'((op_q == wba_pkg::OP_AVG_TX) ? tx_sum : rx_sum)
                           << wba_pkg::AVG_SHIFT;
      end
      wba_pkg::OP_SUG: begin
        div_req.divisor  = (dir_q == wba_pkg::DIR_UP) ? wba_pkg::MS_W'(wba_pkg::UP_DIV) :
                                                        wba_pkg::MS_W'(wba_pkg::DOWN_DIV);
        div_req.pairs    = wba_pkg::CNT_W'(wba_pkg::SUG_PAIRS);
        div_req.dvd_init = wba_pkg::DVD_W'(sug_prod) << wba_pkg::SUG_SHIFT;
      end
      default: ;
    endcase
    div_req.start = (state_q == wba_pkg::ST_LOAD) && !(rt_op && ms_zero);
  end

  // decision compare and clamp
  always_comb begin
    rx_up = (RW + 7)'(avg_rx_q) * (RW + 7)'(wba_pkg::RX_UP_WEIGHT);
    tx_up = (RW + 7)'(avg_tx_q) * (RW + 7)'(wba_pkg::TX_UP_WEIGHT);
    rx_dn = (RW + 7)'(avg_rx_q) * (RW + 7)'(wba_pkg::RX_DOWN_WEIGHT);
    tx_dn = (RW + 7)'(avg_tx_q) * (RW + 7)'(wba_pkg::TX_DOWN_WEIGHT);
    if (cur_q == '0) begin
      dir_c = wba_pkg::DIR_HOLD;
    end else if (rx_up >= tx_up) begin
      dir_c = wba_pkg::DIR_UP;
    end else if (rx_dn < tx_dn) begin
      dir_c = wba_pkg::DIR_DOWN;
    end else begin
      dir_c = wba_pkg::DIR_HOLD;
    end
    lo_clamp = (sug_q < RW'(min_q)) ? RW'(min_q) : sug_q;
    hi_clamp = (lo_clamp > RW'(max_q)) ? RW'(max_q) : lo_clamp;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wba_pkg::ST_IDLE;
      op_q    <= wba_pkg::OP_MS_TX;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    hist_ctrl = '0;
    case (state_q)
      wba_pkg::ST_IDLE: begin
        if (s_axis_tvalid && !ignore) begin
          state_d = wba_pkg::ST_LOAD;
          op_d    = wba_pkg::OP_MS_TX;
        end
      end
      wba_pkg::ST_LOAD: begin
        if (rt_op && ms_zero) begin
          if (op_q == wba_pkg::OP_RT_TX) begin
            op_d = wba_pkg::OP_MS_RX;
          end else begin
            state_d = wba_pkg::ST_RD;
          end
        end else begin
          state_d = wba_pkg::ST_WAIT;
        end
      end
      wba_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = wba_pkg::ST_LOAD;
          case (op_q)
            wba_pkg::OP_MS_TX:  op_d = wba_pkg::OP_RT_TX;
            wba_pkg::OP_RT_TX:  op_d = wba_pkg::OP_MS_RX;
            wba_pkg::OP_MS_RX:  op_d = wba_pkg::OP_RT_RX;
            wba_pkg::OP_RT_RX:  state_d = wba_pkg::ST_RD;
            wba_pkg::OP_AVG_TX: op_d = wba_pkg::OP_AVG_RX;
            wba_pkg::OP_AVG_RX: state_d = wba_pkg::ST_CMP;
            wba_pkg::OP_SUG:    state_d = wba_pkg::ST_CLAMP;
            default:            state_d = wba_pkg::ST_IDLE;
          endcase
        end
      end
      wba_pkg::ST_RD: begin
        hist_ctrl.rd = 1'b1;
        state_d      = wba_pkg::ST_PUSH;
      end
      wba_pkg::ST_PUSH: begin
        hist_ctrl.push = 1'b1;
        if (decide) begin
          state_d = wba_pkg::ST_LOAD;
          op_d    = wba_pkg::OP_AVG_TX;
        end else begin
          state_d = wba_pkg::ST_IDLE;
        end
      end
      wba_pkg::ST_CMP: begin
        if (dir_c != wba_pkg::DIR_HOLD) begin
          state_d = wba_pkg::ST_LOAD;
          op_d    = wba_pkg::OP_SUG;
        end else begin
          state_d = wba_pkg::ST_OUT;
        end
      end
      wba_pkg::ST_CLAMP: state_d = wba_pkg::ST_OUT;
      wba_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = wba_pkg::ST_IDLE;
        end
      end
      default: state_d = wba_pkg::ST_IDLE;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sent_q  <= s_axis_tdata[31:0];
      recv_q  <= s_axis_tdata[63:32];
      lspan_q <= s_axis_tdata[127:64];
      rspan_q <= s_axis_tdata[191:128];
      cur_q   <= s_axis_tdata[222:192];
    end
    if ((state_q == wba_pkg::ST_LOAD) && rt_op && ms_zero) begin
      if (op_q == wba_pkg::OP_RT_TX) begin
        tx_q <= '0;
      end else begin
        rx_q <= '0;
      end
    end
    if ((state_q == wba_pkg::ST_WAIT) && div_rsp.done) begin
      case (op_q)
        wba_pkg::OP_MS_TX, wba_pkg::OP_MS_RX: ms_q <= quot[wba_pkg::MS_W-1:0];
        wba_pkg::OP_RT_TX:  tx_q     <= rate_sat;
        wba_pkg::OP_RT_RX:  rx_q     <= rate_sat;
        wba_pkg::OP_AVG_TX: avg_tx_q <= quot[RW-1:0];
        wba_pkg::OP_AVG_RX: avg_rx_q <= quot[RW-1:0];
        wba_pkg::OP_SUG:    sug_q    <= quot[RW-1:0];
        default: ;
      endcase
    end
    if (state_q == wba_pkg::ST_CMP) begin
      dir_q  <= dir_c;
      next_q <= cur_q;
    end
    if (state_q == wba_pkg::ST_CLAMP) begin
      next_q <= hi_clamp[KW-1:0];
    end
    if (out_load) begin
      o_avg_tx_q <= avg_tx_q;
      o_avg_rx_q <= avg_rx_q;
      o_prior_q  <= cur_q;
      o_next_q   <= next_q;
      o_dir_q    <= dir_q;
      o_apply_q  <= next_q != cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, o_apply_q, o_dir_q, o_next_q, o_prior_q, o_avg_rx_q, o_avg_tx_q};

endmodule

/* hdl/wba_chk.sv */
// port-level checks on decision beats of the windowed bitrate adapter
// depends on wba_pkg; bound to windowed_bitrate_adapter

module wba_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [wba_pkg::OUT_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("decision beat changed while stalled");

  a_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[128] == (m_axis_tdata[125:95] != m_axis_tdata[94:64]))
    else $error("apply flag does not match rate change");

  a_hold_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[127:126] == wba_pkg::DIR_HOLD)
      |-> m_axis_tdata[125:95] == m_axis_tdata[94:64])
    else $error("hold decision changed the rate");

endmodule

bind windowed_bitrate_adapter wba_chk u_wba_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb.sv */
// testbench for windowed_bitrate_adapter: directed and random reports and register settings,
// expected decisions predicted in a scoreboard class and checked per beat
// depends on wba_pkg and the windowed_bitrate_adapter rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wba_pkg::*;

  localparam int unsigned ITEMS        = 550;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned PHASE_LEN    = 55;
  localparam int unsigned IGNORED_LEN  = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int unsigned {
    BAND_UP,
    BAND_HOLD,
    BAND_DOWN
  } band_e;

  // sent_bytes, received_bytes, local_span, remote_span, current_kbps, zero fill
  typedef struct packed {
    logic        zero_pad;
    logic [30:0] current_kbps;
    logic [63:0] remote_span;
    logic [63:0] local_span;
    logic [31:0] received_bytes;
    logic [31:0] sent_bytes;
  } report_t;

  // avg_sent_kbps, avg_received_kbps, prior_kbps, next_kbps, direction, apply_rate, zero fill
  typedef struct packed {
    logic [6:0]  zero_pad;
    logic        apply_rate;
    dir_e        direction;
    logic [30:0] next_kbps;
    logic [30:0] prior_kbps;
    logic [31:0] avg_received_kbps;
    logic [31:0] avg_sent_kbps;
  } decision_t;

  class decision_board;
    logic [30:0] min_kbps;
    logic [30:0] max_kbps;
    logic        attached;
    logic [31:0] sent_hist[WINDOW];
    logic [31:0] recv_hist[WINDOW];
    int unsigned fill;
    int unsigned slot;
    int unsigned since_decision;
    logic [63:0] sent_sum;
    logic [63:0] recv_sum;
    decision_t   expected_q[$];
    int unsigned errors;
    int unsigned matched;

    function new();
      min_kbps       = MIN_KBPS_RST;
      max_kbps       = MAX_KBPS_RST;
      attached       = 1'b0;
      fill           = 0;
      slot           = 0;
      since_decision = 0;
      sent_sum       = '0;
      recv_sum       = '0;
      errors         = 0;
      matched        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
      case (idx)
        REG_MIN_KBPS: min_kbps = val;
        REG_MAX_KBPS: max_kbps = val;
        REG_ATTACHED: attached = val[0];
        default: ;
      endcase
    endfunction

    function bit ignoring();
      return (min_kbps >= max_kbps) || !attached;
    endfunction

    function logic [31:0] kbps_of(logic [31:0] bytes, logic [63:0] span);
      logic [63:0] ms;
      logic [63:0] rate;
      ms = span / 64'd10000;
      if (ms == 0) return '0;
      rate = ({32'd0, bytes} * 64'd8000 / 64'd1024) / ms;
      return (rate > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rate[31:0];
    endfunction

    function void take_report(report_t rp);
      logic [31:0] tx;
      logic [31:0] rx;
      logic [63:0] avg_tx;
      logic [63:0] avg_rx;
      logic [63:0] cur;
      logic [63:0] sug;
      logic [63:0] nxt;
      dir_e        dir;
      decision_t   d;
      tx = kbps_of(rp.sent_bytes, rp.local_span);
      rx = kbps_of(rp.received_bytes, rp.remote_span);
      if (ignoring()) return;
      if (fill >= WINDOW) begin
        sent_sum -= sent_hist[slot];
        recv_sum -= recv_hist[slot];
      end else begin
        fill++;
      end
      sent_hist[slot] = tx;
      recv_hist[slot] = rx;
      sent_sum += tx;
      recv_sum += rx;
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      if (since_decision < DECIDE_EVERY) since_decision++;
      if (fill < WINDOW || since_decision < DECIDE_EVERY) return;
      since_decision = 0;

      avg_tx = sent_sum / 64'(WINDOW);
      avg_rx = recv_sum / 64'(WINDOW);
      cur    = {33'd0, rp.current_kbps};
      nxt    = cur;
      sug    = cur;
      dir    = DIR_HOLD;
      if (cur != 0) begin
        if (avg_rx * 64'(RX_UP_WEIGHT) >= avg_tx * 64'(TX_UP_WEIGHT)) begin
          dir = DIR_UP;
          sug = cur * 64'(UP_MUL) / 64'(UP_DIV);
        end else if (avg_rx * 64'(RX_DOWN_WEIGHT) < avg_tx * 64'(TX_DOWN_WEIGHT)) begin
          dir = DIR_DOWN;
          sug = cur * 64'(DOWN_MUL) / 64'(DOWN_DIV);
        end
        if (dir != DIR_HOLD) begin
          if (sug < {33'd0, min_kbps}) sug = {33'd0, min_kbps};
          if (sug > {33'd0, max_kbps}) sug = {33'd0, max_kbps};
          nxt = sug;
        end
      end
      d                   = '0;
      d.avg_sent_kbps     = avg_tx[31:0];
      d.avg_received_kbps = avg_rx[31:0];
      d.prior_kbps        = cur[30:0];
      d.next_kbps         = nxt[30:0];
      d.direction         = dir;
      d.apply_rate        = (nxt != cur);
      expected_q.push_back(d);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_decision(decision_t got);
      decision_t want;
      if (expected_q.size() == 0) begin
        $error("decision beat with none expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      matched++;
      check_field("avg_sent_kbps", want.avg_sent_kbps, got.avg_sent_kbps);
      check_field("avg_received_kbps", want.avg_received_kbps, got.avg_received_kbps);
      check_field("prior_kbps", want.prior_kbps, got.prior_kbps);
      check_field("next_kbps", want.next_kbps, got.next_kbps);
      check_field("direction", want.direction, got.direction);
      check_field("apply_rate", want.apply_rate, got.apply_rate);
      check_field("zero fill", want.zero_pad, got.zero_pad);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  decision_board sb;
  bit            src_fast;
  bit            snk_fast;
  int unsigned   idle_count;

  windowed_bitrate_adapter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // no beat or register write for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic report_t mk_report(logic [31:0] sent, logic [31:0] recv,
                                        logic [63:0] lspan, logic [63:0] rspan,
                                        logic [30:0] cur);
    report_t rp;
    rp                = '0;
    rp.sent_bytes     = sent;
    rp.received_bytes = recv;
    rp.local_span     = lspan;
    rp.remote_span    = rspan;
    rp.current_kbps   = cur;
    return rp;
  endfunction

  function automatic report_t draw_report(band_e band);
    report_t     rp;
    int unsigned ms;
    int unsigned pct;
    logic [63:0] scaled;
    case (band)
      BAND_UP:   pct = $urandom_range(98, 110);
      BAND_HOLD: pct = $urandom_range(91, 97);
      default:   pct = $urandom_range(20, 89);
    endcase
    ms                = $urandom_range(1, 2000);
    rp                = '0;
    rp.local_span     = 64'(ms) * 64'd10000 + 64'($urandom_range(0, 9999));
    rp.remote_span    = 64'(ms) * 64'd10000 + 64'($urandom_range(0, 9999));
    rp.sent_bytes     = ms * $urandom_range(16, 1024);
    scaled            = 64'(rp.sent_bytes) * 64'(pct) / 64'd100;
    rp.received_bytes = scaled[31:0];
    rp.current_kbps   = ($urandom_range(0, 7) == 0) ? 31'($urandom) :
                                                       31'($urandom_range(1, 6000));
    case ($urandom_range(0, 19))
      0: begin
        rp.sent_bytes     = $urandom;
        rp.received_bytes = $urandom;
        rp.local_span     = {$urandom, $urandom};
        rp.remote_span    = {$urandom, $urandom};
        rp.current_kbps   = 31'($urandom);
      end
      1: begin
        rp.local_span  = 64'($urandom_range(0, 9999));
        rp.remote_span = 64'($urandom_range(0, 9999));
      end
      2: rp.current_kbps = '0;
      3: begin
        rp.local_span     = 64'd10000 + 64'($urandom_range(0, 9999));
        rp.remote_span    = 64'd10000 + 64'($urandom_range(0, 9999));
        rp.sent_bytes     = $urandom | 32'h4000_0000;
        rp.received_bytes = $urandom | 32'h4000_0000;
      end
      default: ;
    endcase
    return rp;
  endfunction

  task automatic send_report(report_t rp);
    int unsigned gap;
    gap = src_fast ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_report(rp);
    if ($urandom_range(0, 15) == 0) src_fast = !src_fast;
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(logic [30:0] lo, logic [30:0] hi, logic att);
    logic [30:0] word;
    word    = 31'($urandom);
    word[0] = att;
    put_reg(REG_MIN_KBPS, lo);
    put_reg(REG_MAX_KBPS, hi);
    put_reg(REG_ATTACHED, word);
    cfg_we_i <= 1'b0;
  endtask

  // block must be quiet before registers change
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = snk_fast ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.match_decision(decision_t'(m_axis_tdata));
      if ($urandom_range(0, 15) == 0) snk_fast = !snk_fast;
    end
  end

  initial begin
    int unsigned useful;
    int unsigned phase;
    int unsigned len;
    logic [30:0] lo;
    logic [30:0] hi;
    logic        att;
    band_e       band;
    sb            = new();
    src_fast      = 1'b0;
    snk_fast      = 1'b0;
    idle_count    = 0;
    band          = BAND_UP;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no encoder after reset: reports are dropped
    send_report(mk_report(32'd5000, 32'd5000, 64'd100000, 64'd100000, 31'd500));
    send_report(mk_report('1, '1, '1, '1, '1));
    wait_idle();
    put_reg(REG_SPARE, 31'h7FFF_FFFF);
    write_regs(31'd200, 31'd1024, 1'b1);

    send_report(mk_report('0, '0, '0, '0, '0));
    send_report(mk_report('1, '1, '1, '1, 31'h7FFF_FFFF));
    send_report(mk_report('1, '1, 64'd10000, 64'd10000, 31'd1000));
    send_report(mk_report('1, '0, 64'd9999, 64'd19999, 31'd500));
    send_report(mk_report(32'd1, 32'd1, 64'd10000, 64'd10000, 31'd1));
    send_report(mk_report(32'd128, 32'd125, 64'd20000, 64'd20000, 31'd300));
    send_report(mk_report(32'd1000000, 32'd980000, 64'd10000000, 64'd10009999, 31'd800));
    send_report(mk_report(32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555, 31'h2AAA_AAAA));
    send_report(mk_report(32'h5555_5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555,
                          64'hAAAA_AAAA_AAAA_AAAA, 31'h5555_5555));
    send_report(mk_report(32'd64000, 32'd57600, 64'd640000, 64'd640000, 31'd2000));
    send_report(mk_report(32'd0, 32'd64000, 64'd640000, 64'd640000, 31'd0));
    send_report(mk_report(32'd64000, 32'd0, 64'd640000, 64'd640000, 31'd150));
    send_report(mk_report(32'h8000_0000, 32'h8000_0000, 64'd30000, 64'd30000, 31'd1024));
    send_report(mk_report(32'd12345, 32'd12000, 64'h8000_0000_0000_0000, 64'd10000,
                          31'd199));
    send_report(mk_report(32'd999, 32'd1000, 64'd19999, 64'd10000, 31'd201));
    send_report(mk_report(32'd7, 32'd7, 64'd10000, 64'd10000, 31'd4000000));

    useful = 0;
    phase  = 0;
    while (useful < ITEMS) begin
      wait_idle();
      att = 1'b1;
      case (phase % 6)
        0: begin lo = 31'd200; hi = 31'd1024; end
        1: begin lo = '0; hi = 31'h7FFF_FFFF; end
        2: begin
          lo = 31'($urandom_range(0, 3000));
          hi = lo + 31'($urandom_range(1, 6000));
        end
        3: begin lo = 31'h7FFF_FFFE; hi = 31'h7FFF_FFFF; end
        4: begin
          case ($urandom_range(0, 2))
            0: begin lo = 31'd500; hi = 31'd500; end
            1: begin lo = 31'd1024; hi = 31'd200; end
            default: begin lo = 31'd200; hi = 31'd1024; att = 1'b0; end
          endcase
        end
        default: begin
          lo = 31'($urandom_range(0, 500));
          hi = lo + 31'($urandom_range(1, 1000000));
        end
      endcase
      write_regs(lo, hi, att);
      len = sb.ignoring() ? IGNORED_LEN : PHASE_LEN;
      for (int unsigned i = 0; i < len; i++) begin
        if (!sb.ignoring() && useful % 30 == 0) band = band_e'($urandom_range(0, 2));
        send_report(draw_report(band));
        if (!sb.ignoring()) useful++;
      end
      phase++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/wba_pkg.sv
hdl/wba_div.sv
hdl/wba_hist.sv
hdl/windowed_bitrate_adapter.sv
hdl/wba_chk.sv
sim/tb.sv
